FILE: sv/dstq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dstq_pkg;

    localparam int TOKEN_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int WAIT_BITS   = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_FIRED = 2'd2
    } status_t;

    typedef struct packed {
        logic                        kind;
        logic signed [WAIT_BITS-1:0] wait_req;
        logic [TOKEN_BITS-1:0]       token;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [TOKEN_BITS-1:0] fired_token;
        logic [TIME_BITS-1:0]  deadline;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  deadline;
        logic [TOKEN_BITS-1:0] token;
    } entry_t;

    // True when deadline a lies strictly before deadline b, modulo wrap.
    function automatic logic time_before(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = a - b;
        return diff[TIME_BITS-1];
    endfunction

endpackage

`default_nettype wire

FILE: sv/deadline_sorted_timer_queue.sv
// Words are taken one at a time: busy stays high until a word is finished; a rejected add
// answers without raising busy. Each step of a shift or a compaction is a memory read
// followed by its write.
// Results are registered and shown for one cycle each; the receiver cannot stall them.
// Reset clears the time counter and the entry count; the entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module deadline_sorted_timer_queue #(
    parameter int QUEUE_DEPTH = dstq_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire dstq_pkg::req_t req,
    output logic              rsp_strobe,
    output dstq_pkg::rsp_t    rsp
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TB = dstq_pkg::TIME_BITS;
    localparam int WB = dstq_pkg::WAIT_BITS;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ARD  = 9'b000000010,
        S_ACMP = 9'b000000100,
        S_SRD  = 9'b000001000,
        S_SWR  = 9'b000010000,
        S_INS  = 9'b000100000,
        S_TRD  = 9'b001000000,
        S_TCMP = 9'b010000000,
        S_TEND = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [TB-1:0]        now_reg, now_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        j_reg, j_next;
    logic                 compact_reg, compact_next;
    dstq_pkg::entry_t     new_reg, new_next;
    dstq_pkg::entry_t     pend_reg, pend_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 rsp_strobe_reg, rsp_strobe_next;
    dstq_pkg::rsp_t       rsp_reg, rsp_next;

    dstq_pkg::entry_t     entry_mem [QUEUE_DEPTH];
    dstq_pkg::entry_t     rd_data_reg;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;
    logic [IW-1:0]        mem_wa;
    dstq_pkg::entry_t     mem_wd;
    logic [TB-1:0]        add_dl;

    assign add_dl = now_reg + {{(TB - WB){req.wait_req[WB-1]}}, req.wait_req};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        compact_next    = compact_reg;
        new_next        = new_reg;
        pend_next       = pend_reg;
        pend_vld_next   = pend_vld_reg;
        rsp_strobe_next = 1'b0;
        rsp_next        = rsp_reg;
        rd_addr         = idx_reg[IW-1:0];
        mem_we          = 1'b0;
        mem_wa          = pos_reg[IW-1:0];
        mem_wd          = new_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.kind == dstq_pkg::KIND_ADD)
                    begin
                        new_next.deadline = add_dl;
                        new_next.token    = req.token;
                        idx_next          = '0;
                        pos_next          = '0;
                        compact_next      = 1'b0;
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            rsp_strobe_next      = 1'b1;
                            rsp_next.status      = dstq_pkg::ST_FULL;
                            rsp_next.fired_token = req.token;
                            rsp_next.deadline    = add_dl;
                            rsp_next.last        = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_INS;
                        end
                        else
                        begin
                            state_next = S_ARD;
                        end
                    end
                    else
                    begin
                        now_next      = now_reg + TB'(1);
                        idx_next      = '0;
                        pend_vld_next = 1'b0;
                        compact_next  = 1'b0;
                        if (count_reg != '0)
                        begin
                            state_next = S_TRD;
                        end
                    end
                end
            end

            S_ARD:
            begin
                rd_addr    = idx_reg[IW-1:0];
                state_next = S_ACMP;
            end

            S_ACMP:
            begin
                if (dstq_pkg::time_before(new_reg.deadline, rd_data_reg.deadline))
                begin
                    pos_next   = idx_reg;
                    j_next     = count_reg;
                    state_next = S_SRD;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = S_INS;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_ARD;
                end
            end

            S_SRD:
            begin
                rd_addr    = j_reg[IW-1:0] - IW'(1);
                state_next = S_SWR;
            end

            S_SWR:
            begin
                mem_we = 1'b0;
                if (compact_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = j_reg[IW-1:0] - idx_reg[IW-1:0];
                    mem_wd = rd_data_reg;
                    if (j_reg + CW'(1) == count_reg)
                    begin
                        count_next = count_reg - idx_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = j_reg[IW-1:0];
                    mem_wd = rd_data_reg;
                    j_next = j_reg - CW'(1);
                    if (j_reg - CW'(1) == pos_reg)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end

            S_INS:
            begin
                mem_we               = 1'b1;
                mem_wa               = pos_reg[IW-1:0];
                mem_wd               = new_reg;
                count_next           = count_reg + CW'(1);
                rsp_strobe_next      = 1'b1;
                rsp_next.status      = dstq_pkg::ST_ADDED;
                rsp_next.fired_token = new_reg.token;
                rsp_next.deadline    = new_reg.deadline;
                rsp_next.last        = 1'b1;
                state_next           = S_IDLE;
            end

            S_TRD:
            begin
                rd_addr    = idx_reg[IW-1:0];
                state_next = S_TCMP;
            end

            S_TCMP:
            begin
                if (!dstq_pkg::time_before(now_reg, rd_data_reg.deadline))
                begin
                    if (pend_vld_reg)
                    begin
                        rsp_strobe_next      = 1'b1;
                        rsp_next.status      = dstq_pkg::ST_FIRED;
                        rsp_next.fired_token = pend_reg.token;
                        rsp_next.deadline    = pend_reg.deadline;
                        rsp_next.last        = 1'b0;
                    end
                    pend_next     = rd_data_reg;
                    pend_vld_next = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        state_next = S_TEND;
                    end
                    else
                    begin
                        state_next = S_TRD;
                    end
                end
                else if (pend_vld_reg)
                begin
                    state_next = S_TEND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_TEND:
            begin
                rsp_strobe_next      = 1'b1;
                rsp_next.status      = dstq_pkg::ST_FIRED;
                rsp_next.fired_token = pend_reg.token;
                rsp_next.deadline    = pend_reg.deadline;
                rsp_next.last        = 1'b1;
                pend_vld_next        = 1'b0;
                j_next               = idx_reg;
                if (idx_reg == count_reg)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    compact_next = 1'b1;
                    state_next   = S_SRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // During compaction the read runs forward from the first entry left behind.
        if (state_reg == S_SRD && compact_reg)
        begin
            rd_addr = j_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            j_reg          <= '0;
            compact_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
            rsp_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            j_reg          <= j_next;
            compact_reg    <= compact_next;
            pend_vld_reg   <= pend_vld_next;
            rsp_strobe_reg <= rsp_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg  <= new_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign rsp_strobe = rsp_strobe_reg;
    assign rsp        = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && rsp.status == dstq_pkg::ST_FULL |-> count_reg == CW'(QUEUE_DEPTH))
        else $error("full status reported with free entries");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.kind == dstq_pkg::KIND_TICK |=> now_reg == $past(now_reg) + TB'(1))
        else $error("tick did not advance time by one");

    a_fired_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && rsp.status == dstq_pkg::ST_FIRED && !rsp.last |-> busy)
        else $error("fired word without last while the queue went idle");

endmodule

`default_nettype wire

FILE: test/tb_deadline_sorted_timer_queue.sv
`timescale 1ns / 1ps

module tb_deadline_sorted_timer_queue;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIME_W = dstq_pkg::TIME_BITS;
    localparam int TOKEN_W = dstq_pkg::TOKEN_BITS;
    localparam int WAIT_W = dstq_pkg::WAIT_BITS;

    typedef struct {
        dstq_pkg::req_t word;
        bit             typed;
        dstq_pkg::rsp_t answer;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    dstq_pkg::req_t req;
    logic rsp_strobe;
    dstq_pkg::rsp_t rsp;

    logic [TIME_W-1:0]    now_ticks;
    dstq_pkg::entry_t     held_entries[dstq_pkg::QUEUE_DEPTH];
    int                   held_count;
    dstq_pkg::rsp_t       timer_rsp_q[$];
    plan_row_t            plan[$];
    int                   fault_count = 0;
    int                   cycle_count = 0;

    deadline_sorted_timer_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // A deadline is due when the current time is not strictly before it, modulo wrap.
    function automatic bit runs_earlier(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] gap;
        gap = a - b;
        return gap[TIME_W-1];
    endfunction

    function automatic void apply_timer_word(input dstq_pkg::req_t w);
        logic signed [TIME_W-1:0] delay;
        logic [TIME_W-1:0]        due;
        dstq_pkg::rsp_t           r;
        int                       pos;
        int                       fired;
        bit                       found;
        if (w.kind == dstq_pkg::KIND_ADD)
        begin
            delay = w.wait_req;
            due = now_ticks + delay;
            r.fired_token = w.token;
            r.deadline = due;
            r.last = 1'b1;
            if (held_count >= dstq_pkg::QUEUE_DEPTH)
            begin
                r.status = dstq_pkg::ST_FULL;
            end
            else
            begin
                pos = held_count;
                found = 1'b0;
                for (int i = 0; i < held_count; i++)
                begin
                    if (!found && runs_earlier(due, held_entries[i].deadline))
                    begin
                        pos = i;
                        found = 1'b1;
                    end
                end
                for (int i = held_count; i > pos; i--)
                    held_entries[i] = held_entries[i-1];
                held_entries[pos].deadline = due;
                held_entries[pos].token = w.token;
                held_count++;
                r.status = dstq_pkg::ST_ADDED;
            end
            timer_rsp_q.push_back(r);
        end
        else
        begin
            now_ticks = now_ticks + 1'b1;
            fired = 0;
            while (fired < held_count && !runs_earlier(now_ticks, held_entries[fired].deadline))
                fired++;
            for (int i = 0; i < fired; i++)
            begin
                r.status = dstq_pkg::ST_FIRED;
                r.fired_token = held_entries[i].token;
                r.deadline = held_entries[i].deadline;
                r.last = (i == fired - 1);
                timer_rsp_q.push_back(r);
            end
            for (int i = fired; i < held_count; i++)
                held_entries[i-fired] = held_entries[i];
            held_count -= fired;
        end
    endfunction

    always @(posedge clk)
    begin
        dstq_pkg::rsp_t want;
        if (rst_n === 1'b1 && rsp_strobe === 1'b1)
        begin
            if (timer_rsp_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Unexpected word: status %0d token %h deadline %h last %b",
                             rsp.status, rsp.fired_token, rsp.deadline, rsp.last);
            end
            else
            begin
                want = timer_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.fired_token !== want.fired_token ||
                    rsp.deadline !== want.deadline || rsp.last !== want.last)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"Mismatch: expected status %0d token %h deadline %h last %b,",
                                  " got status %0d token %h deadline %h last %b"},
                                 want.status, want.fired_token, want.deadline, want.last,
                                 rsp.status, rsp.fired_token, rsp.deadline, rsp.last);
                end
            end
        end
    end

    task automatic issue_word(input dstq_pkg::req_t w, input int gap, input bit typed,
                              input dstq_pkg::rsp_t answer);
        start <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (busy);
        apply_timer_word(w);
        if (typed)
        begin
            void'(timer_rsp_q.pop_back());
            timer_rsp_q.push_back(answer);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic plan_row(input logic kind, input logic signed [WAIT_W-1:0] wait_val,
                            input logic [TOKEN_W-1:0] tok, input bit typed,
                            input dstq_pkg::status_t st, input logic [TIME_W-1:0] due);
        plan_row_t row;
        row.word.kind = kind;
        row.word.wait_req = wait_val;
        row.word.token = tok;
        row.typed = typed;
        row.answer.status = st;
        row.answer.fired_token = tok;
        row.answer.deadline = due;
        row.answer.last = 1'b1;
        plan.push_back(row);
    endtask

    function automatic dstq_pkg::req_t random_word(input int tick_pct);
        dstq_pkg::req_t w;
        int             pick;
        w.kind = ($urandom_range(99) < tick_pct) ? dstq_pkg::KIND_TICK : dstq_pkg::KIND_ADD;
        pick = $urandom_range(9);
        if (pick == 0)
            w.wait_req = WAIT_W'($urandom);
        else if (pick < 3)
            w.wait_req = WAIT_W'(0 - $urandom_range(3));
        else
            w.wait_req = WAIT_W'($urandom_range(1, 12));
        w.token = TOKEN_W'($urandom);
        return w;
    endfunction

    initial
    begin
        int             tick_mix[8];
        bit             idling;
        int             gap;
        dstq_pkg::req_t w;
        tick_mix = '{25, 45, 70, 45, 10, 80, 45, 50};
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        now_ticks = '0;
        held_count = 0;

        plan_row(dstq_pkg::KIND_ADD, 8'sd0, 16'h0000, 1'b1, dstq_pkg::ST_ADDED, 32'd0);
        plan_row(dstq_pkg::KIND_ADD, 8'sd127, 16'hFFFF, 1'b1, dstq_pkg::ST_ADDED, 32'd127);
        plan_row(dstq_pkg::KIND_ADD, -8'sd128, 16'h1234, 1'b1, dstq_pkg::ST_ADDED,
                 32'hFFFF_FF80);
        plan_row(dstq_pkg::KIND_ADD, 8'sd0, 16'h5555, 1'b1, dstq_pkg::ST_ADDED, 32'd0);
        plan_row(dstq_pkg::KIND_TICK, 8'sd0, 16'h0000, 1'b0, dstq_pkg::ST_FIRED, 32'd0);
        plan_row(dstq_pkg::KIND_TICK, -8'sd1, 16'hFFFF, 1'b0, dstq_pkg::ST_FIRED, 32'd0);
        for (int i = 0; i < 15; i++)
            plan_row(dstq_pkg::KIND_ADD, -8'sd1, TOKEN_W'(16'h0100 + i), 1'b1,
                     dstq_pkg::ST_ADDED, 32'd1);
        plan_row(dstq_pkg::KIND_ADD, 8'sd5, 16'hABCD, 1'b1, dstq_pkg::ST_FULL, 32'd7);
        plan_row(dstq_pkg::KIND_TICK, 8'sd0, 16'h0000, 1'b0, dstq_pkg::ST_FIRED, 32'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < plan.size(); r++)
        begin
            if (r == plan.size() - 1)
                gap = 1;
            else
                gap = ($urandom_range(2) == 0) ? $urandom_range(1, 13) : 0;
            issue_word(plan[r].word, gap, plan[r].typed, plan[r].answer);
        end
        while (timer_rsp_q.size() != 0)
            @(posedge clk);

        for (int phase = 0; phase < 8; phase++)
        begin
            idling = (phase < 7) && (phase % 2 == 0 || phase == 5);
            for (int n = 0; n < 50; n++)
            begin
                w = random_word(tick_mix[phase]);
                gap = (idling && $urandom_range(3) == 0) ? $urandom_range(1, 13) : 0;
                if ((phase == 3 || phase == 7) && n == 49)
                    gap = 1;
                issue_word(w, gap, 1'b0, '0);
            end
            if (phase == 3)
            begin
                while (timer_rsp_q.size() != 0)
                    @(posedge clk);
            end
        end

        while (timer_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && timer_rsp_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/dstq_pkg.sv
sv/deadline_sorted_timer_queue.sv
test/tb_deadline_sorted_timer_queue.sv
